// ===== rtl/core/rbst_pkg.sv =====
// shared types and constants for the ray versus box slab test
`default_nettype none
package rbst_pkg;

  localparam int Q_W       = 32;  // width of a signed q16.16 value
  localparam int FRAC_BITS = 16;  // fraction bits of q16.16
  localparam int SIGN_W    = 3;   // one swap bit per axis
  localparam int AXES      = 3;
  localparam int ADDR_W    = 5;   // seven 32-bit registers at byte address 4*i

  localparam logic [Q_W-1:0] ORIGIN_RESET  = '0;
  localparam logic [Q_W-1:0] INV_DIR_RESET = Q_W'(1) << FRAC_BITS;  // 1.0

  // register index, byte address bits [4:2]
  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_INV_DIR_X = 3'd3,
    REG_INV_DIR_Y = 3'd4,
    REG_INV_DIR_Z = 3'd5,
    REG_SIGN_SEL  = 3'd6
  } reg_idx_t;

  // one box word
  typedef struct packed {
    logic [Q_W-1:0] box_min_x;
    logic [Q_W-1:0] box_min_y;
    logic [Q_W-1:0] box_min_z;
    logic [Q_W-1:0] box_max_x;
    logic [Q_W-1:0] box_max_y;
    logic [Q_W-1:0] box_max_z;
    logic [Q_W-1:0] t_in_near;
    logic [Q_W-1:0] t_in_far;
  } box_req_t;

  // one result word
  typedef struct packed {
    logic           hit;
    logic [Q_W-1:0] t_out_near;
    logic [Q_W-1:0] t_out_far;
  } box_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/ray_box_slab_test_top.sv =====
// top level of the ray versus axis-aligned box slab test
`default_nettype none
// done is high in the same cycle as the result on rsp
// throughput: one box word per cycle, busy is low outside reset, no stall anywhere
// depth is set by the per-axis subtract, multiply and scale stages plus three
// compare stages (pairwise max/min, final max/min, hit compare)
// reset (rst, synchronous, active high): origin 0, inverse direction 1.0, no swap,
// all pipeline valid bits cleared; the receiver cannot stall, so done is a one-cycle strobe
module ray_box_slab_test_top (
  input  logic                       clk,
  input  logic                       rst,
  // box stream
  input  logic                       start,
  output logic                       busy,
  input  rbst_pkg::box_req_t         req,
  output logic                       done,
  output rbst_pkg::box_rsp_t         rsp,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rbst_pkg::*;

  // ray registers
  logic [Q_W-1:0]    origin  [AXES];
  logic [Q_W-1:0]    inv_dir [AXES];
  logic [SIGN_W-1:0] sign_sel;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  // valid bits: stages a, b, c (slab units), d, e (reduction)
  logic v_a, v_b, v_c, v_d, v_e;
  logic accept;

  // incoming interval carried alongside the slab units
  logic [Q_W-1:0] tn_a, tn_b, tn_c;
  logic [Q_W-1:0] tf_a, tf_b, tf_c;

  // slab outputs, per axis
  logic [Q_W-1:0] p_near [AXES];
  logic [Q_W-1:0] p_far  [AXES];

  // reduction registers
  logic [Q_W-1:0] near_01, near_2, far_01, far_2;
  logic [Q_W-1:0] near_fin, far_fin;

  logic [Q_W-1:0] box_lo [AXES];
  logic [Q_W-1:0] box_hi [AXES];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  // register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        origin[a]  <= ORIGIN_RESET;
        inv_dir[a] <= INV_DIR_RESET;
      end
      sign_sel <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X:  origin[0]  <= pwdata[Q_W-1:0];
        REG_ORIGIN_Y:  origin[1]  <= pwdata[Q_W-1:0];
        REG_ORIGIN_Z:  origin[2]  <= pwdata[Q_W-1:0];
        REG_INV_DIR_X: inv_dir[0] <= pwdata[Q_W-1:0];
        REG_INV_DIR_Y: inv_dir[1] <= pwdata[Q_W-1:0];
        REG_INV_DIR_Z: inv_dir[2] <= pwdata[Q_W-1:0];
        REG_SIGN_SEL:  sign_sel   <= pwdata[SIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X:  prdata = origin[0];
      REG_ORIGIN_Y:  prdata = origin[1];
      REG_ORIGIN_Z:  prdata = origin[2];
      REG_INV_DIR_X: prdata = inv_dir[0];
      REG_INV_DIR_Y: prdata = inv_dir[1];
      REG_INV_DIR_Z: prdata = inv_dir[2];
      REG_SIGN_SEL:  prdata = {{(32-SIGN_W){1'b0}}, sign_sel};
      default:       prdata = '0;
    endcase
  end

  // the pipeline never stalls, so a word is taken every cycle that start is high outside reset
  assign busy   = rst;
  assign accept = start && !busy;

  assign box_lo[0] = req.box_min_x;
  assign box_lo[1] = req.box_min_y;
  assign box_lo[2] = req.box_min_z;
  assign box_hi[0] = req.box_max_x;
  assign box_hi[1] = req.box_max_y;
  assign box_hi[2] = req.box_max_z;

  // one slab unit per axis: subtract (a), multiply (b), scale and clamp (c)
  for (genvar g = 0; g < AXES; g++) begin : g_axis
    rbst_slab u_slab (
      .clk     (clk),
      .lo      (box_lo[g]),
      .hi      (box_hi[g]),
      .swap    (sign_sel[g]),
      .origin  (origin[g]),
      .inv_dir (inv_dir[g]),
      .t_near  (p_near[g]),
      .t_far   (p_far[g])
    );
  end

  // valid line, travels with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a  <= 1'b0;
      v_b  <= 1'b0;
      v_c  <= 1'b0;
      v_d  <= 1'b0;
      v_e  <= 1'b0;
      done <= 1'b0;
    end else begin
      v_a  <= accept;
      v_b  <= v_a;
      v_c  <= v_b;
      v_d  <= v_c;
      v_e  <= v_d;
      done <= v_e;
    end
  end

  // data line
  always_ff @(posedge clk) begin
    // interval delay matching the slab units
    tn_a <= req.t_in_near;
    tf_a <= req.t_in_far;
    tn_b <= tn_a;
    tf_b <= tf_a;
    tn_c <= tn_b;
    tf_c <= tf_b;

    // stage d: pairwise max of near, min of far
    near_01 <= ($signed(tn_c) > $signed(p_near[0])) ? tn_c : p_near[0];
    near_2  <= ($signed(p_near[1]) > $signed(p_near[2])) ? p_near[1] : p_near[2];
    far_01  <= ($signed(tf_c) < $signed(p_far[0])) ? tf_c : p_far[0];
    far_2   <= ($signed(p_far[1]) < $signed(p_far[2])) ? p_far[1] : p_far[2];

    // stage e: narrowed interval
    near_fin <= ($signed(near_01) > $signed(near_2)) ? near_01 : near_2;
    far_fin  <= ($signed(far_01) < $signed(far_2)) ? far_01 : far_2;

    // output word: hit when near does not exceed far
    rsp.hit        <= ($signed(near_fin) <= $signed(far_fin));
    rsp.t_out_near <= near_fin;
    rsp.t_out_far  <= far_fin;
  end

endmodule
`default_nettype wire

// ===== rtl/core/rbst_slab.sv =====
// one axis of the slab test: bound select, subtract, multiply, scale and saturate
`default_nettype none
module rbst_slab (
  input  logic                    clk,
  input  logic [rbst_pkg::Q_W-1:0] lo,
  input  logic [rbst_pkg::Q_W-1:0] hi,
  input  logic                    swap,
  input  logic [rbst_pkg::Q_W-1:0] origin,
  input  logic [rbst_pkg::Q_W-1:0] inv_dir,
  output logic [rbst_pkg::Q_W-1:0] t_near,
  output logic [rbst_pkg::Q_W-1:0] t_far
);
  import rbst_pkg::*;

  localparam int D_W = Q_W + 1;        // exact bound minus origin
  localparam int P_W = D_W + Q_W;      // exact product
  localparam int S_W = P_W - FRAC_BITS;

  logic [Q_W-1:0]        near_bound;
  logic [Q_W-1:0]        far_bound;
  logic signed [D_W-1:0] diff_near;
  logic signed [D_W-1:0] diff_far;
  logic signed [P_W-1:0] prod_near;
  logic signed [P_W-1:0] prod_far;

  // divide by 2^16 toward zero, then clamp to the signed 32-bit range
  function automatic logic [Q_W-1:0] scale_sat(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] biased;
    logic [S_W-1:0]        q;
    logic [Q_W-1:0]        r;
    biased = p + $signed({{(P_W-FRAC_BITS){1'b0}}, {FRAC_BITS{p[P_W-1]}}});
    q = biased[P_W-1:FRAC_BITS];
    if ((&q[S_W-1:Q_W-1]) || !(|q[S_W-1:Q_W-1])) begin
      r = q[Q_W-1:0];
    end else if (q[S_W-1]) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign near_bound = swap ? hi : lo;
  assign far_bound  = swap ? lo : hi;

  // stage a: difference, stage b: product, stage c: scaled result
  always_ff @(posedge clk) begin
    diff_near <= $signed({near_bound[Q_W-1], near_bound}) - $signed({origin[Q_W-1], origin});
    diff_far  <= $signed({far_bound[Q_W-1], far_bound}) - $signed({origin[Q_W-1], origin});
    prod_near <= diff_near * $signed(inv_dir);
    prod_far  <= diff_far * $signed(inv_dir);
    t_near    <= scale_sat(prod_near);
    t_far     <= scale_sat(prod_far);
  end

endmodule
`default_nettype wire

// ===== verif/tb_ray_box_slab_test_top.sv =====
// self-checking testbench for the ray versus box slab test top level
module tb_ray_box_slab_test_top;
  import rbst_pkg::*;

  // handy q16.16 corner values
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [Q_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [Q_W-1:0] Q_NEG1 = 32'hffff_ffff;  // -1 lsb
  // register slot past the last one, writes there must be dropped
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  // leave plenty of slack at the end for the pipeline to empty
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // box stream
  logic start = 1'b0;
  logic busy;
  box_req_t req = '0;
  logic done;
  box_rsp_t rsp;

  // configuration port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_box_slab_test_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // period of 2 time units
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // our own copy of the ray registers, reset values first
  logic [Q_W-1:0] ray_org [AXES] = '{ORIGIN_RESET, ORIGIN_RESET, ORIGIN_RESET};
  logic [Q_W-1:0] ray_inv [AXES] = '{INV_DIR_RESET, INV_DIR_RESET, INV_DIR_RESET};
  logic [SIGN_W-1:0] ray_sign = '0;

  box_req_t pending_boxes [$];   // box words waiting to be driven
  box_rsp_t predicted_rsp [$];   // narrowed intervals still to come out
  box_rsp_t want;
  int n_target = 0;              // box words queued so far
  int n_issued = 0;              // box words taken by the block
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  logic took = 1'b0;             // the word on req was taken at the last edge
  bit no_gaps = 1'b0;            // back-to-back stretch

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one slab crossing: (bound - origin) * inv, scaled by 2^-16 toward zero,
  // clamped to the signed 32-bit range; the difference keeps all 33 bits
  function automatic longint slab_param(logic [Q_W-1:0] bound, logic [Q_W-1:0] org,
                                        logic [Q_W-1:0] inv);
    longint diff;
    longint prod;
    longint q;
    diff = longint'($signed(bound)) - longint'($signed(org));
    prod = diff * longint'($signed(inv));
    q = prod / (longint'(1) << FRAC_BITS);  // signed divide truncates toward zero
    if (q > longint'(32'sh7fff_ffff)) return longint'(32'sh7fff_ffff);
    if (q < -longint'(64'sh8000_0000)) return -longint'(64'sh8000_0000);
    return q;
  endfunction

  // narrow the incoming interval by all three slabs
  function automatic box_rsp_t slab_narrow(box_req_t b);
    logic [Q_W-1:0] lo [AXES];
    logic [Q_W-1:0] hi [AXES];
    longint tn;
    longint tf;
    longint pn;
    longint pf;
    box_rsp_t r;
    lo[0] = b.box_min_x;
    lo[1] = b.box_min_y;
    lo[2] = b.box_min_z;
    hi[0] = b.box_max_x;
    hi[1] = b.box_max_y;
    hi[2] = b.box_max_z;
    tn = longint'($signed(b.t_in_near));
    tf = longint'($signed(b.t_in_far));
    for (int a = 0; a < AXES; a++) begin
      // sign bit set: the max corner is met first
      pn = slab_param(ray_sign[a] ? hi[a] : lo[a], ray_org[a], ray_inv[a]);
      pf = slab_param(ray_sign[a] ? lo[a] : hi[a], ray_org[a], ray_inv[a]);
      if (pn > tn) tn = pn;
      if (pf < tf) tf = pf;
    end
    r.hit = (tn <= tf);
    r.t_out_near = tn[Q_W-1:0];
    r.t_out_far = tf[Q_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // moderate signed value, about +-64.0
  function automatic logic [Q_W-1:0] modest_q();
    return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
  endfunction

  // anything at all, corners weighted up
  function automatic logic [Q_W-1:0] noise_q();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return '0;
          3: return Q_NEG1;
          default: return Q_ONE;
        endcase
      end
      1: return modest_q();
      default: return $urandom;
    endcase
  endfunction

  // proper box around a random center, usual traversal interval
  function automatic box_req_t tame_box();
    box_req_t b;
    logic [Q_W-1:0] c;
    logic [Q_W-1:0] h;
    c = modest_q();
    h = $urandom_range(0, 32'h0010_0000);
    b.box_min_x = c - h;
    b.box_max_x = c + h;
    c = modest_q();
    h = $urandom_range(0, 32'h0010_0000);
    b.box_min_y = c - h;
    b.box_max_y = c + h;
    c = modest_q();
    h = $urandom_range(0, 32'h0010_0000);
    b.box_min_z = c - h;
    b.box_max_z = c + h;
    b.t_in_near = ($urandom_range(0, 3) == 0) ? modest_q() : '0;
    b.t_in_far = ($urandom_range(0, 3) == 0) ? {1'b0, 31'($urandom)} : Q_MAX;
    return b;
  endfunction

  function automatic box_req_t noise_box();
    box_req_t b;
    b.box_min_x = noise_q();
    b.box_min_y = noise_q();
    b.box_min_z = noise_q();
    b.box_max_x = noise_q();
    b.box_max_y = noise_q();
    b.box_max_z = noise_q();
    b.t_in_near = noise_q();
    b.t_in_far = noise_q();
    return b;
  endfunction

  // idle cycles after a word: mostly none or a few, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_box(input box_req_t b);
    pending_boxes.push_back(b);
    n_target++;
  endtask

  task automatic push_box(input logic [Q_W-1:0] x0, y0, z0, x1, y1, z1, tn, tf);
    box_req_t b;
    b.box_min_x = x0;
    b.box_min_y = y0;
    b.box_min_z = z0;
    b.box_max_x = x1;
    b.box_max_y = y1;
    b.box_max_z = z1;
    b.t_in_near = tn;
    b.t_in_far = tf;
    queue_box(b);
  endtask

  // hold off until every queued word went in and its result came back
  task automatic wait_drained();
    while (n_issued != n_target || predicted_rsp.size() != 0) @(negedge clk);
  endtask

  // apb write, then read back what landed in a mapped register
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want_rd;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X:  ray_org[0] = val;
      REG_ORIGIN_Y:  ray_org[1] = val;
      REG_ORIGIN_Z:  ray_org[2] = val;
      REG_INV_DIR_X: ray_inv[0] = val;
      REG_INV_DIR_Y: ray_inv[1] = val;
      REG_INV_DIR_Z: ray_inv[2] = val;
      REG_SIGN_SEL:  ray_sign = val[SIGN_W-1:0];
      default: ;  // unmapped, dropped
    endcase
    @(negedge clk);
    if (idx <= REG_SIGN_SEL) begin
      want_rd = (idx == REG_SIGN_SEL) ? {29'b0, val[SIGN_W-1:0]} : val;
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata !== want_rd) begin
        $display("%0t: register %0d readback expected %h actual %h",
                 $time, idx, want_rd, prdata);
        errors++;
      end
      @(negedge clk);
    end
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // a new ray: tame ones look like a real traversal, with sign bits that follow
  // the direction; wild ones are raw bits, saturation nearly everywhere
  task automatic random_ray(input bit tame);
    logic [Q_W-1:0] org;
    logic [Q_W-1:0] inv;
    logic [Q_W-1:0] mag;
    logic [SIGN_W-1:0] sgn;
    for (int a = 0; a < AXES; a++) begin
      if (tame) begin
        org = modest_q();
        mag = $urandom_range(32'h0000_0400, 32'h0010_0000);
        sgn[a] = $urandom_range(0, 1);
        inv = ($urandom_range(0, 19) == 0) ? '0 : (sgn[a] ? -mag : mag);
      end else begin
        org = noise_q();
        inv = noise_q();
        sgn[a] = $urandom_range(0, 1);
      end
      cfg_write(REG_ORIGIN_X + 3'(a), org);
      cfg_write(REG_INV_DIR_X + 3'(a), inv);
    end
    // wild rays also put junk in the unused upper bits of the sign register
    cfg_write(REG_SIGN_SEL, tame ? {29'b0, sgn} : {29'($urandom), sgn});
  endtask

  // ---------------------------------------------------------------------------
  // driver: one box word per handshake, held until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // still waiting for the block to take the current word
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_boxes.size() > 0) begin
      req <= pending_boxes.pop_front();
      start <= 1'b1;
      gap_left <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict at acceptance, check each strobed result against the oldest
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    took <= start && !busy;
    if (!rst) begin
      if (done) begin
        if (predicted_rsp.size() == 0) begin
          $display("%0t: result with nothing expected: hit %b near %h far %h",
                   $time, rsp.hit, rsp.t_out_near, rsp.t_out_far);
          errors++;
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp.hit !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, rsp.hit);
            errors++;
          end
          if (rsp.t_out_near !== want.t_out_near) begin
            $display("%0t: t_out_near expected %h actual %h",
                     $time, want.t_out_near, rsp.t_out_near);
            errors++;
          end
          if (rsp.t_out_far !== want.t_out_far) begin
            $display("%0t: t_out_far expected %h actual %h",
                     $time, want.t_out_far, rsp.t_out_far);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predicted_rsp.push_back(slab_narrow(req));
        n_issued++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** ray_box_slab_test_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // single synchronous reset at the start
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset ray: origin 0, inverse direction 1.0, no swap, so each slab
    // crossing equals the bound itself
    push_box('0, '0, '0, '0, '0, '0, '0, '0);                 // degenerate point
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
    push_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX);  // inverted box
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_ONE, '0);     // inverted interval
    push_box(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_MIN, Q_MAX);  // near equals far
    push_box(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE + 1, Q_MAX);  // just past
    push_box(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1);
    push_box(Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, '0, Q_MAX);
    push_box(Q_ONE, 3 * Q_ONE, Q_ONE, 2 * Q_ONE, 4 * Q_ONE, 2 * Q_ONE, '0, Q_MAX);  // miss
    wait_drained();

    // extreme ray: products saturate both ways, z has zero inverse direction,
    // x and z swapped
    cfg_write(REG_ORIGIN_X, Q_MIN);
    cfg_write(REG_INV_DIR_X, Q_MAX);
    cfg_write(REG_ORIGIN_Y, Q_MAX);
    cfg_write(REG_INV_DIR_Y, Q_MIN);
    cfg_write(REG_ORIGIN_Z, Q_ONE);
    cfg_write(REG_INV_DIR_Z, '0);
    cfg_write(REG_SIGN_SEL, 32'h0000_0005);
    push_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
    push_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, '0, '0);
    for (int i = 0; i < 4; i++) queue_box(noise_box());
    wait_drained();

    // tiny inverse direction, all swapped: results come from rounding toward zero
    cfg_write(REG_ORIGIN_X, '0);
    cfg_write(REG_ORIGIN_Y, '0);
    cfg_write(REG_ORIGIN_Z, '0);
    cfg_write(REG_INV_DIR_X, 32'h0000_0001);
    cfg_write(REG_INV_DIR_Y, 32'h0000_0001);
    cfg_write(REG_INV_DIR_Z, 32'hffff_ffff);
    cfg_write(REG_SIGN_SEL, 32'h0000_0007);
    push_box(-32'd65537, -32'd1, 32'd65537, 32'd65537, 32'd1, -32'd65537, Q_MIN, Q_MAX);
    push_box(-32'd131071, -32'd65536, 32'd131071, 32'd131071, 32'd65536, -32'd131071,
             Q_MIN, Q_MAX);
    wait_drained();

    // a write past the last register must change nothing
    cfg_write(REG_UNMAPPED, 32'hdead_beef);

    // random rays with random boxes, one run back to back, one with wild rays
    for (int p = 0; p < 5; p++) begin
      random_ray(p != 2);
      no_gaps = (p == 1);
      for (int i = 0; i < 200; i++) begin
        // sender pauses mid-phase until the pipe is empty
        if (i == 100) wait_drained();
        queue_box(($urandom_range(0, 4) != 0) ? tame_box() : noise_box());
      end
      wait_drained();
    end

    // back to the reset ray as a last setting
    cfg_write(REG_ORIGIN_X, ORIGIN_RESET);
    cfg_write(REG_ORIGIN_Y, ORIGIN_RESET);
    cfg_write(REG_ORIGIN_Z, ORIGIN_RESET);
    cfg_write(REG_INV_DIR_X, INV_DIR_RESET);
    cfg_write(REG_INV_DIR_Y, INV_DIR_RESET);
    cfg_write(REG_INV_DIR_Z, INV_DIR_RESET);
    cfg_write(REG_SIGN_SEL, '0);
    for (int i = 0; i < 20; i++) queue_box(noise_box());
    wait_drained();

    // let any stray strobe show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** ray_box_slab_test_top: PASSED **");
    end else begin
      $display("** ray_box_slab_test_top: FAILED **");
    end
    $finish;
  end

endmodule
